// ----- sv/mpsm_pkg.sv -----
`timescale 1ns / 1ps

package mpsm_pkg;

   // Default sizes of the pattern store.
   localparam int PATTERN_ROWS_DEF = 8;
   localparam int MAX_PAT_LEN_DEF  = 16;

   // Fixed widths of the channel fields.
   localparam int REQ_TYPE_W = 2;
   localparam int IDX_IN_W   = 3;
   localparam int POS_IN_W   = 4;
   localparam int DATA_W     = 8;
   localparam int LEN_IN_W   = 5;
   localparam int HIT_W      = 8;
   localparam int PKT_NUM_W  = 16;
   localparam int COUNT_W    = 4;

   // Queue between the front and back parts; the depth is a power of two.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_PAT_BYTE  = 2'd0,
      REQ_PAT_LEN   = 2'd1,
      REQ_PKT_BYTE  = 2'd2,
      REQ_PKT_EMPTY = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      OP_PAT_BYTE,
      OP_PAT_LEN,
      OP_PKT_BYTE,
      OP_PKT_LAST,
      OP_PKT_EMPTY
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [IDX_IN_W-1:0]   idx;
      logic [POS_IN_W-1:0]   pos;
      logic [DATA_W-1:0]     data;
      logic [LEN_IN_W-1:0]   len;
   } item_type;

endpackage

// ----- sv/mpsm_ifs.sv -----
`timescale 1ns / 1ps

interface mpsm_req_if;
   logic                             valid;
   logic                             ready;
   logic [mpsm_pkg::REQ_TYPE_W-1:0]  req_type;
   logic [mpsm_pkg::IDX_IN_W-1:0]    pattern_index;
   logic [mpsm_pkg::POS_IN_W-1:0]    byte_position;
   logic [mpsm_pkg::DATA_W-1:0]      data_byte;
   logic [mpsm_pkg::LEN_IN_W-1:0]    pattern_length;
   logic                             last_byte;

   modport source (
      output valid, req_type, pattern_index, byte_position, data_byte,
             pattern_length, last_byte,
      input  ready
   );
   modport sink (
      input  valid, req_type, pattern_index, byte_position, data_byte,
             pattern_length, last_byte,
      output ready
   );
endinterface

interface mpsm_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [mpsm_pkg::HIT_W-1:0]       hit_mask;
   logic [mpsm_pkg::PKT_NUM_W-1:0]   packet_number;

   modport source (output valid, hit_mask, packet_number, input ready);
   modport sink   (input valid, hit_mask, packet_number, output ready);
endinterface

interface mpsm_csr_if;
   logic                             valid;
   logic                             ready;
   logic [mpsm_pkg::COUNT_W-1:0]     pattern_count;

   modport source (output valid, pattern_count, input ready);
   modport sink   (input valid, pattern_count, output ready);
endinterface

// ----- sv/mpsm_front.sv -----
`timescale 1ns / 1ps

module mpsm_front #(
   parameter int PATTERN_ROWS = mpsm_pkg::PATTERN_ROWS_DEF,
   parameter int MAX_PAT_LEN  = mpsm_pkg::MAX_PAT_LEN_DEF
) (
   input  logic               clock,
   input  logic               reset,
   mpsm_req_if.sink           req_chan,
   output logic               q_valid,
   output mpsm_pkg::item_type q_item,
   input  logic               q_ready
);

   localparam int LenInW = mpsm_pkg::LEN_IN_W;
   localparam int Depth  = mpsm_pkg::QUEUE_DEPTH;
   localparam int PtrW   = mpsm_pkg::QPTR_W;
   localparam int CntW   = mpsm_pkg::QCNT_W;

   mpsm_pkg::item_type item;
   logic               keep;
   logic               push;
   logic               pop;

   mpsm_pkg::item_type queue_ff [Depth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;

   // Classify the incoming item; loads that address nothing are dropped here.
   always_comb begin
      item.idx  = req_chan.pattern_index;
      item.pos  = req_chan.byte_position;
      item.data = req_chan.data_byte;
      item.len  = (32'(req_chan.pattern_length) > MAX_PAT_LEN) ?
                  LenInW'(MAX_PAT_LEN) : req_chan.pattern_length;
      unique case (mpsm_pkg::req_code_type'(req_chan.req_type))
         mpsm_pkg::REQ_PAT_BYTE: begin
            item.op = mpsm_pkg::OP_PAT_BYTE;
            keep    = (32'(req_chan.pattern_index) < PATTERN_ROWS) &&
                      (32'(req_chan.byte_position) < MAX_PAT_LEN);
         end
         mpsm_pkg::REQ_PAT_LEN: begin
            item.op = mpsm_pkg::OP_PAT_LEN;
            keep    = 32'(req_chan.pattern_index) < PATTERN_ROWS;
         end
         mpsm_pkg::REQ_PKT_BYTE: begin
            item.op = req_chan.last_byte ? mpsm_pkg::OP_PKT_LAST : mpsm_pkg::OP_PKT_BYTE;
            keep    = 1'b1;
         end
         mpsm_pkg::REQ_PKT_EMPTY: begin
            item.op = mpsm_pkg::OP_PKT_EMPTY;
            keep    = 1'b1;
         end
         default: begin
            item.op = mpsm_pkg::OP_PKT_BYTE;
            keep    = 1'b0;
         end
      endcase
   end

   assign req_chan.ready = (cnt_ff != CntW'(Depth));
   assign q_valid        = (cnt_ff != '0);
   assign q_item         = queue_ff[rd_ptr_ff];

   assign push = req_chan.valid && req_chan.ready && keep;
   assign pop  = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PtrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + CntW'(push) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ----- sv/mpsm_back.sv -----
`timescale 1ns / 1ps

module mpsm_back #(
   parameter int PATTERN_ROWS = mpsm_pkg::PATTERN_ROWS_DEF,
   parameter int MAX_PAT_LEN  = mpsm_pkg::MAX_PAT_LEN_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  mpsm_pkg::item_type q_item,
   output logic               q_ready,
   mpsm_csr_if.sink           csr_chan,
   mpsm_rsp_if.source         rsp_chan
);

   localparam int IdxW   = (PATTERN_ROWS > 1) ? $clog2(PATTERN_ROWS) : 1;
   localparam int PosW   = (MAX_PAT_LEN > 1) ? $clog2(MAX_PAT_LEN) : 1;
   localparam int LenW   = $clog2(MAX_PAT_LEN + 1);
   localparam int DataW  = mpsm_pkg::DATA_W;
   localparam int HitW   = mpsm_pkg::HIT_W;
   localparam int PktW   = mpsm_pkg::PKT_NUM_W;
   localparam int CountW = mpsm_pkg::COUNT_W;

   logic [DataW-1:0]        pat_ff [PATTERN_ROWS][MAX_PAT_LEN];
   logic [LenW-1:0]         len_ff [PATTERN_ROWS];
   logic [DataW-1:0]        win_ff [MAX_PAT_LEN];
   logic [DataW-1:0]        win_in [MAX_PAT_LEN];
   logic [LenW-1:0]         fill_ff, fill_in, fill_sh;
   logic [PATTERN_ROWS-1:0] sticky_ff, sticky_in, hit;
   logic [PktW-1:0]         pkt_ff, pkt_in;
   logic [CountW-1:0]       count_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [HitW-1:0]         mask_ff, mask_in;
   logic [PktW-1:0]         num_ff, num_in;
   logic                    closes;
   logic                    is_byte;
   logic                    go;
   logic                    emit;

   assign closes  = (q_item.op == mpsm_pkg::OP_PKT_LAST) ||
                    (q_item.op == mpsm_pkg::OP_PKT_EMPTY);
   assign is_byte = (q_item.op == mpsm_pkg::OP_PKT_BYTE) ||
                    (q_item.op == mpsm_pkg::OP_PKT_LAST);
   assign q_ready = !closes || !rsp_valid_ff || rsp_chan.ready;
   assign go      = q_valid && q_ready;

   // Window after the new byte has been shifted in.
   always_comb begin
      for (int j = 0; j < MAX_PAT_LEN - 1; j++) begin
         win_in[j] = win_ff[j + 1];
      end
      win_in[MAX_PAT_LEN - 1] = q_item.data;
      fill_sh = (fill_ff < LenW'(MAX_PAT_LEN)) ? fill_ff + LenW'(1) : fill_ff;
   end

   // Every pattern row compares its bytes against the tail of the window at once.
   always_comb begin
      for (int r = 0; r < PATTERN_ROWS; r++) begin
         hit[r] = (len_ff[r] != '0) && (len_ff[r] <= fill_sh) && (r < int'(count_ff));
         for (int k = 0; k < MAX_PAT_LEN; k++) begin
            if (k < int'(len_ff[r])) begin
               hit[r] = hit[r] &&
                  (win_in[PosW'(MAX_PAT_LEN - int'(len_ff[r]) + k)] == pat_ff[r][k]);
            end
         end
      end
   end

   always_comb begin
      sticky_in = sticky_ff;
      fill_in   = fill_ff;
      pkt_in    = pkt_ff;
      mask_in   = mask_ff;
      num_in    = num_ff;
      emit      = 1'b0;
      if (go) begin
         unique case (q_item.op)
            mpsm_pkg::OP_PKT_BYTE: begin
               sticky_in = sticky_ff | hit;
               fill_in   = fill_sh;
            end
            mpsm_pkg::OP_PKT_LAST: begin
               emit      = 1'b1;
               mask_in   = HitW'(sticky_ff | hit);
               num_in    = pkt_ff;
               pkt_in    = pkt_ff + PktW'(1);
               sticky_in = '0;
               fill_in   = '0;
            end
            mpsm_pkg::OP_PKT_EMPTY: begin
               emit      = 1'b1;
               mask_in   = HitW'(sticky_ff);
               num_in    = pkt_ff;
               pkt_in    = pkt_ff + PktW'(1);
               sticky_in = '0;
               fill_in   = '0;
            end
            default: begin
            end
         endcase
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   end

   assign csr_chan.ready         = 1'b1;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.hit_mask      = mask_ff;
   assign rsp_chan.packet_number = num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < PATTERN_ROWS; r++) begin
            len_ff[r] <= '0;
         end
         fill_ff      <= '0;
         sticky_ff    <= '0;
         pkt_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (go && (q_item.op == mpsm_pkg::OP_PAT_LEN)) begin
            len_ff[IdxW'(q_item.idx)] <= LenW'(q_item.len);
         end
         if (csr_chan.valid) begin
            count_ff <= csr_chan.pattern_count;
         end
         fill_ff      <= fill_in;
         sticky_ff    <= sticky_in;
         pkt_ff       <= pkt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go && (q_item.op == mpsm_pkg::OP_PAT_BYTE)) begin
         pat_ff[IdxW'(q_item.idx)][PosW'(q_item.pos)] <= q_item.data;
      end
      if (go && is_byte) begin
         win_ff <= win_in;
      end
      mask_ff <= mask_in;
      num_ff  <= num_in;
   end

endmodule

// ----- sv/multi_pattern_substring_match.sv -----
// A packet-closing item is held in the queue until the back stage takes it; its result is then
// written into the result register at the output, which drives it until it is taken.
// Throughput: one item per cycle while the back stage is not stalled, as it compares every pattern at once.
// A held result stalls the back stage only on a packet-closing item; the two-entry queue
// keeps taking items until it is full. Reset (synchronous, active high) clears lengths, hits,
// window fill, packet number, pattern count and the queue; pattern and window bytes hold.
`timescale 1ns / 1ps

// Top level of the multi-pattern substring matcher.
//
// The front part decodes each request item into an internal operation, drops
// load items that address a pattern row or byte that does not exist, clamps
// pattern lengths to the row length and queues the rest. The back part holds
// the pattern rows, the packet byte window and the sticky hit vector, and
// executes one queued item per cycle in arrival order, so pattern loads made
// in the middle of a packet take effect from the next packet byte.
//
// A result register sits at the output. The back part only waits when it has
// a packet-closing item to retire while an earlier result is still held.
module multi_pattern_substring_match #(
   parameter int PATTERN_ROWS = mpsm_pkg::PATTERN_ROWS_DEF,
   parameter int MAX_PAT_LEN  = mpsm_pkg::MAX_PAT_LEN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mpsm_req_if.sink   req_chan,
   mpsm_rsp_if.source rsp_chan,
   mpsm_csr_if.sink   csr_chan
);

   // Queue head handed from the front part to the back part.
   logic               q_valid;
   logic               q_ready;
   mpsm_pkg::item_type q_item;

   mpsm_front #(
      .PATTERN_ROWS (PATTERN_ROWS),
      .MAX_PAT_LEN  (MAX_PAT_LEN)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_ready  (q_ready)
   );

   // The back part also owns the pattern count register, which the user must
   // write only while no item is in flight; the block does not enforce it.
   mpsm_back #(
      .PATTERN_ROWS (PATTERN_ROWS),
      .MAX_PAT_LEN  (MAX_PAT_LEN)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_ready  (q_ready),
      .csr_chan (csr_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- sv/mpsm_checker.sv -----
`timescale 1ns / 1ps

module mpsm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic [mpsm_pkg::REQ_TYPE_W-1:0]  req_type,
   input logic                             req_last,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [mpsm_pkg::HIT_W-1:0]       hit_mask,
   input logic [mpsm_pkg::PKT_NUM_W-1:0]   packet_number
);

   localparam int PktW = mpsm_pkg::PKT_NUM_W;

   logic            end_seen;
   logic            rsp_taken;
   logic [2:0]      pend_ff;
   logic [PktW-1:0] next_num_ff;

   assign end_seen  = req_valid && req_ready &&
                      ((req_type == mpsm_pkg::REQ_PKT_EMPTY) ||
                       ((req_type == mpsm_pkg::REQ_PKT_BYTE) && req_last));
   assign rsp_taken = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= '0;
         next_num_ff <= '0;
      end else begin
         pend_ff <= pend_ff + 3'(end_seen) - 3'(rsp_taken);
         if (rsp_taken) begin
            next_num_ff <= next_num_ff + PktW'(1);
         end
      end
   end

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(hit_mask) && $stable(packet_number))
      else $error("result changed while stalled");

   a_number_seq : assert property (@(posedge clock) disable iff (reset)
      rsp_taken |-> packet_number == next_num_ff)
      else $error("packet number out of sequence");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != '0)
      else $error("result without a closed packet");

endmodule

bind multi_pattern_substring_match mpsm_checker u_mpsm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_type      (req_chan.req_type),
   .req_last      (req_chan.last_byte),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .hit_mask      (rsp_chan.hit_mask),
   .packet_number (rsp_chan.packet_number)
);
